// File: rtl/core/matrix_multiply_engine_macros.svh
// assertion macros of the matrix multiply engine, used by mme_ctrl
// no dependencies; included by files that carry concurrent assertions
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define MME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mme_pkg.sv
// shared types, codes and helpers of the matrix multiply engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mme_pkg;

    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = 3;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int FRAC_W      = 16;
    localparam int DEF_MAX_DIM = 8;

    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [DATA_W-1:0] elem_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] product_value;
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic                     last_flag;
        logic                     status;
    } t_out_item;

    typedef struct packed {
        logic                     wr_a;
        logic                     wr_b;
        logic signed [DATA_W-1:0] wr_data;
        logic                     mac_vld;
        logic                     mac_first;
        logic                     mac_last;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         j;
        logic                     load_out;
        logic                     out_last;
        logic                     out_err;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_dp_stat;

    // register value 0 acts as 1, above the limit acts as the limit
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] d;
        d = v;
        if (v == '0) begin
            d = CFG_W'(1);
        end else if (v > lim) begin
            d = lim;
        end
        return d;
    endfunction

endpackage

// File: rtl/core/mme_ctrl.sv
// sequencer of the matrix multiply engine: config registers, item intake,
// dot product walk and result hand-off; uses mme_pkg and the macro header
`timescale 1ns / 1ps
`include "matrix_multiply_engine_macros.svh"

module mme_ctrl
    import mme_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_item,
    output logic                 o_in_stall,
    output t_dp_cmd              o_cmd,
    input  t_dp_stat             i_stat
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [CFG_W-1:0] DIM_LIM = CFG_W'(MAX_DIM);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_row, n_row;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_j, n_j;
    logic             r_err, n_err;
    logic [CFG_W-1:0] r_rows_a, r_inner_a, r_rows_b, r_cols_b;

    logic [CFG_W-1:0] ra, na, rb, cb;
    logic             in_acc;
    logic             row_last, col_last, j_last;

    assign ra = eff_dim(r_rows_a, DIM_LIM);
    assign na = eff_dim(r_inner_a, DIM_LIM);
    assign rb = eff_dim(r_rows_b, DIM_LIM);
    assign cb = eff_dim(r_cols_b, DIM_LIM);

    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign row_last = (CFG_W'(r_row) + CFG_W'(1)) == ra;
    assign col_last = (CFG_W'(r_col) + CFG_W'(1)) == cb;
    assign j_last   = (CFG_W'(r_j) + CFG_W'(1)) == na;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a  <= CFG_W'(8);
            r_inner_a <= CFG_W'(8);
            r_rows_b  <= CFG_W'(8);
            r_cols_b  <= CFG_W'(8);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ROWS_A:  r_rows_a  <= i_cfg_wr_data;
                REG_INNER_A: r_inner_a <= i_cfg_wr_data;
                REG_ROWS_B:  r_rows_b  <= i_cfg_wr_data;
                REG_COLS_B:  r_cols_b  <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_j     = r_j;
        n_err   = r_err;

        o_cmd           = '0;
        o_cmd.wr_data   = i_in_item.elem_value;
        o_cmd.row       = r_row;
        o_cmd.col       = r_col;
        o_cmd.j         = r_j;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd.row = i_in_item.row_index;
                o_cmd.col = i_in_item.col_index;
                if (in_acc) begin
                    unique case (i_in_item.mode)
                        MODE_LOAD_A: begin
                            o_cmd.wr_a = (CFG_W'(i_in_item.row_index) < ra) &&
                                         (CFG_W'(i_in_item.col_index) < na);
                        end
                        MODE_LOAD_B: begin
                            o_cmd.wr_b = (CFG_W'(i_in_item.row_index) < rb) &&
                                         (CFG_W'(i_in_item.col_index) < cb);
                        end
                        MODE_COMPUTE: begin
                            n_row = '0;
                            n_col = '0;
                            n_j   = '0;
                            if (na != rb) begin
                                n_err   = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                n_state = ST_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                o_cmd.mac_vld   = 1'b1;
                o_cmd.mac_first = (r_j == '0);
                o_cmd.mac_last  = j_last;
                if (j_last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            ST_WAIT: begin
                if (i_stat.acc_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_err  = r_err;
                    o_cmd.out_last = r_err || (row_last && col_last);
                    if (r_err || (row_last && col_last)) begin
                        n_err   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_j     = '0;
                        n_state = ST_MAC;
                        if (row_last) begin
                            n_row = '0;
                            n_col = r_col + IDX_W'(1);
                        end else begin
                            n_row = r_row + IDX_W'(1);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_err   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
        r_row <= n_row;
        r_col <= n_col;
        r_j   <= n_j;
    end

    `MME_ASSERT_IMPL(a_emit_when_free, i_clk, i_rst_n, o_cmd.load_out, i_stat.out_free, "result written while output register busy")
    `MME_ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, i_stat.acc_done, r_state == ST_WAIT, "accumulation finished outside wait state")
    `MME_ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, r_state == ST_MAC, (CFG_W'(r_row) < ra) && (CFG_W'(r_col) < cb) && (CFG_W'(r_j) < na), "product walk index out of range")
    `MME_ASSERT_NEXT(a_last_mac_waits, i_clk, i_rst_n, o_cmd.mac_vld && o_cmd.mac_last, r_state == ST_WAIT, "last multiply not followed by wait")

endmodule

// File: rtl/core/mme_dp.sv
// datapath of the matrix multiply engine: element stores, multiply and
// accumulate pipeline, rounding, saturation and output register; uses mme_pkg
`timescale 1ns / 1ps

module mme_dp
    import mme_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
    localparam int HI_W   = ACC_W - DATA_W + 1;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

    logic signed [DATA_W-1:0] r_a_rd, r_b_rd;
    logic                     r_s1_vld, r_s1_first, r_s1_last;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_s2_vld, r_s2_first, r_s2_last;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_acc_done;

    logic signed [ACC_W-1:0]  prod_ext, n_acc, acc_shr;
    logic [HI_W-1:0]          acc_hi;
    logic signed [DATA_W-1:0] sat_val;

    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;

    assign wr_addr = ADDR_W'(i_cmd.row * MAX_DIM + i_cmd.col);
    assign a_addr  = ADDR_W'(i_cmd.row * MAX_DIM + i_cmd.j);
    assign b_addr  = ADDR_W'(i_cmd.j * MAX_DIM + i_cmd.col);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            mem_a[wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.wr_b) begin
            mem_b[wr_addr] <= i_cmd.wr_data;
        end
        r_a_rd <= mem_a[a_addr];
        r_b_rd <= mem_b[b_addr];
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign n_acc    = r_s2_first ? prod_ext : r_acc + prod_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_vld   <= i_cmd.mac_vld;
            r_s2_vld   <= r_s1_vld;
            r_acc_done <= r_s2_vld && r_s2_last;
        end
        r_s1_first <= i_cmd.mac_first;
        r_s1_last  <= i_cmd.mac_last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= r_a_rd * r_b_rd;
        if (r_s2_vld) begin
            r_acc <= n_acc;
        end
    end

    // floor to q16.16, then clamp to 32 bits
    assign acc_shr = r_acc >>> FRAC_W;
    assign acc_hi  = acc_shr[ACC_W-1:DATA_W-1];

    always_comb begin
        if ((acc_hi == '0) || (acc_hi == '1)) begin
            sat_val = acc_shr[DATA_W-1:0];
        end else if (acc_shr[ACC_W-1]) begin
            sat_val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_val = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    always_comb begin
        n_out.product_value = i_cmd.out_err ? '0 : sat_val;
        n_out.out_row       = i_cmd.out_err ? '0 : i_cmd.row;
        n_out.out_col       = i_cmd.out_err ? '0 : i_cmd.col;
        n_out.last_flag     = i_cmd.out_last;
        n_out.status        = i_cmd.out_err;
    end

    assign o_stat.out_free = !r_out_vld || !i_out_stall;
    assign o_stat.acc_done = r_acc_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// File: rtl/core/matrix_multiply_engine.sv
// Dense matrix multiply engine for signed q16.16 matrices up to MAX_DIM square.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries items: a load of
// one element of A or B, addressed by row and column, or a compute request.
// Loads outside the configured sizes and items with the unused mode are dropped.
// Output channel (o_out_valid / i_out_stall / o_out_item) returns the product
// one element per item in column-major order, last_flag set on the final one.
// A compute with inner_a different from rows_b returns one item with status 1.
// Sizes are set through a write port (i_cfg_wr_en / i_cfg_index / i_cfg_wr_data)
// while the block is idle, a rule on the user that the block does not enforce;
// 0 counts as 1, values above MAX_DIM as MAX_DIM. A compute walks one
// multiply-accumulate per cycle through the single 32x32 multiplier for each
// term of a product element; the sum passes the read, product, accumulator
// and done registers, is handed off; the input is held until the last hand-off.
// The output register lets the next item in while the final result waits.
// A stalled receiver holds the walk at the next hand-off; nothing is dropped.
// Synchronous reset restores all sizes to 8 and empties the output register;
// the element stores keep no reset value and must be loaded before use.
// Depends on mme_pkg, mme_ctrl and mme_dp.
`timescale 1ns / 1ps

module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wr_data,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mme_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_item     (i_in_item),
        .o_in_stall    (o_in_stall),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    mme_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// File: tb/matrix_multiply_engine_test.sv
// self-checking testbench for matrix_multiply_engine: loads a and b, requests products,
// and compares every product element against a q16.16 scoreboard kept in the testbench
// depends on mme_pkg and the matrix_multiply_engine rtl
`timescale 1ns / 1ps

module matrix_multiply_engine_test;
    import mme_pkg::*;

    localparam int DIM        = DEF_MAX_DIM;
    localparam int MAT_N      = DIM * DIM;
    localparam int ITEM_GOAL  = 410;
    localparam int QUIET_AT   = 350;
    localparam int SETTLE     = 20;
    localparam int DRAIN_MAX  = 100000;
    localparam logic signed [71:0] Q_MAX = 72'sh7FFF_FFFF;
    localparam logic signed [71:0] Q_MIN = -72'sh8000_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    t_in_item             in_item = '0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;

    int counted = 0;
    int idle_level = 0;
    int stall_left = 0;

    class product_scoreboard;
        logic [CFG_W-1:0]         size_reg[4];
        logic signed [DATA_W-1:0] a_elem[MAT_N];
        logic signed [DATA_W-1:0] b_elem[MAT_N];
        bit                       a_loaded[MAT_N];
        bit                       b_loaded[MAT_N];
        t_out_item                expected_q[$];
        int                       errors;

        function new();
            foreach (size_reg[i]) size_reg[i] = CFG_W'(8);
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            size_reg[idx] = v;
        endfunction

        function int dim(logic [CFG_IDX_W-1:0] idx);
            int v;
            v = size_reg[idx];
            if (v == 0) return 1;
            if (v > DIM) return DIM;
            return v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // returns 1 when the item has an effect on the block
        function bit note_input(t_in_item it);
            int ra, na, rb, cb, pos;
            logic signed [63:0] pa, pb;
            logic signed [71:0] acc, q;
            t_out_item res;
            ra  = dim(REG_ROWS_A);
            na  = dim(REG_INNER_A);
            rb  = dim(REG_ROWS_B);
            cb  = dim(REG_COLS_B);
            pos = it.row_index * DIM + it.col_index;
            case (it.mode)
                MODE_LOAD_A: begin
                    if (it.row_index < ra && it.col_index < na) begin
                        a_elem[pos] = it.elem_value;
                        a_loaded[pos] = 1'b1;
                        return 1'b1;
                    end
                end
                MODE_LOAD_B: begin
                    if (it.row_index < rb && it.col_index < cb) begin
                        b_elem[pos] = it.elem_value;
                        b_loaded[pos] = 1'b1;
                        return 1'b1;
                    end
                end
                MODE_COMPUTE: begin
                    if (na != rb) begin
                        res = '0;
                        res.last_flag = 1'b1;
                        res.status = 1'b1;
                        expected_q.push_back(res);
                        return 1'b1;
                    end
                    for (int c = 0; c < cb; c++) begin
                        for (int r = 0; r < ra; r++) begin
                            acc = '0;
                            for (int j = 0; j < na; j++) begin
                                pa = a_elem[r * DIM + j];
                                pb = b_elem[j * DIM + c];
                                acc += pa * pb;
                            end
                            // floor to q16.16, then clamp
                            q = acc >>> FRAC_W;
                            if (q > Q_MAX) q = Q_MAX;
                            if (q < Q_MIN) q = Q_MIN;
                            res.product_value = q[DATA_W-1:0];
                            res.out_row = IDX_W'(r);
                            res.out_col = IDX_W'(c);
                            res.last_flag = (c == cb - 1) && (r == ra - 1);
                            res.status = 1'b0;
                            expected_q.push_back(res);
                        end
                    end
                    return 1'b1;
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("product_value", want.product_value, got.product_value);
            compare_field("out_row", want.out_row, got.out_row);
            compare_field("out_col", want.out_col, got.out_col);
            compare_field("last_flag", want.last_flag, got.last_flag);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    product_scoreboard sb = new();

    matrix_multiply_engine u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_item     (in_item),
        .o_in_stall    (in_stall),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver stalls in bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idle_level != 0 && counted < QUIET_AT &&
                     $urandom_range(0, idle_level == 1 ? 11 : 3) == 0) begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(out_item);
        end
    end

    function automatic t_in_item mk_item(logic [1:0] mode, int row, int col,
                                         logic [31:0] value);
        t_in_item it;
        it.mode = mode;
        it.row_index = IDX_W'(row);
        it.col_index = IDX_W'(col);
        it.elem_value = value;
        return it;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3: return $urandom;
            default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_size();
        case ($urandom_range(0, 19))
            0: return CFG_W'(0);
            1: return CFG_W'($urandom_range(9, 15));
            2: return CFG_W'(8);
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        if (idle_level != 0 && counted < QUIET_AT &&
            $urandom_range(0, idle_level == 1 ? 9 : 2) == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        if (sb.note_input(it)) counted++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_sizes(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] na,
                             logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb);
        drain();
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_INNER_A, na);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
    endtask

    // ignored modes, stray addresses, and ordinary loads mixed in
    task automatic send_load(logic [1:0] mode, int row, int col);
        logic [1:0] noise_mode;
        if ($urandom_range(0, 7) == 0) begin
            noise_mode = ($urandom_range(0, 2) == 0) ? 2'd3 : 2'($urandom_range(0, 1));
            send_item(mk_item(noise_mode, $urandom_range(0, 7), $urandom_range(0, 7),
                              $urandom));
        end
        send_item(mk_item(mode, row, col, rand_value()));
    endtask

    task automatic run_sequence();
        int ra, na, rb, cb, extra;
        ra = sb.dim(REG_ROWS_A);
        na = sb.dim(REG_INNER_A);
        rb = sb.dim(REG_ROWS_B);
        cb = sb.dim(REG_COLS_B);
        if (na == rb) begin
            for (int r = 0; r < ra; r++)
                for (int j = 0; j < na; j++)
                    if (!sb.a_loaded[r * DIM + j]) send_load(MODE_LOAD_A, r, j);
            for (int j = 0; j < rb; j++)
                for (int c = 0; c < cb; c++)
                    if (!sb.b_loaded[j * DIM + c]) send_load(MODE_LOAD_B, j, c);
        end
        extra = $urandom_range(0, 6);
        repeat (extra) begin
            if ($urandom_range(0, 1) == 0) begin
                send_load(MODE_LOAD_A, $urandom_range(0, ra - 1), $urandom_range(0, na - 1));
            end else begin
                send_load(MODE_LOAD_B, $urandom_range(0, rb - 1), $urandom_range(0, cb - 1));
            end
        end
        send_item(mk_item(MODE_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
    endtask

    task automatic run_directed();
        set_sizes(2, 2, 2, 2);
        // saturation both ways
        send_item(mk_item(MODE_LOAD_A, 0, 0, 32'h7FFF_FFFF));
        send_item(mk_item(MODE_LOAD_A, 0, 1, 32'h7FFF_FFFF));
        send_item(mk_item(MODE_LOAD_A, 1, 0, 32'h8000_0000));
        send_item(mk_item(MODE_LOAD_A, 1, 1, 32'hFFFF_FFFF));
        send_item(mk_item(MODE_LOAD_B, 0, 0, 32'h7FFF_FFFF));
        send_item(mk_item(MODE_LOAD_B, 1, 0, 32'h7FFF_FFFF));
        send_item(mk_item(MODE_LOAD_B, 0, 1, 32'h8000_0000));
        send_item(mk_item(MODE_LOAD_B, 1, 1, 32'h0001_0000));
        // loads outside the sizes and the unused mode, then a compute
        send_item(mk_item(MODE_LOAD_A, 7, 7, 32'h5A5A_5A5A));
        send_item(mk_item(MODE_LOAD_B, 2, 0, 32'hA5A5_A5A5));
        send_item(mk_item(2'd3, 7, 7, 32'hFFFF_FFFF));
        send_item(mk_item(2'd3, 0, 0, 32'h0000_0000));
        send_item(mk_item(MODE_COMPUTE, 7, 7, 32'hFFFF_FFFF));
        // inner dimension mismatch
        set_sizes(2, 3, 2, 2);
        send_item(mk_item(MODE_COMPUTE, 0, 0, 32'h0000_0000));
        // zero sizes act as one, tiny negative product rounds down
        set_sizes(0, 0, 0, 0);
        send_item(mk_item(MODE_LOAD_A, 0, 0, 32'hFFFF_FFFF));
        send_item(mk_item(MODE_LOAD_B, 0, 0, 32'h0000_8000));
        send_item(mk_item(MODE_COMPUTE, 0, 0, 32'h0000_0000));
        // oversized register acts as the limit, mismatching inner
        set_sizes(0, 0, 15, 0);
        send_item(mk_item(MODE_COMPUTE, 3, 5, 32'h1234_5678));
    endtask

    initial begin
        int phase;
        int waited;
        logic [CFG_W-1:0] ra, na, rb, cb;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        idle_level = 1;
        run_directed();
        counted = 0;

        phase = 0;
        while (counted < ITEM_GOAL) begin
            if (phase == 0) begin
                ra = 15; na = 15; rb = 15; cb = 15;
            end else if (phase == 1) begin
                ra = 8; na = 1; rb = 1; cb = 8;
            end else begin
                ra = rand_size();
                na = rand_size();
                cb = rand_size();
                if ($urandom_range(0, 4) == 0) begin
                    rb = rand_size();
                end else if (na >= 8 && $urandom_range(0, 1) == 1) begin
                    rb = CFG_W'($urandom_range(8, 15));
                end else begin
                    rb = na;
                end
            end
            idle_level = (counted < QUIET_AT) ? $urandom_range(0, 2) : 0;
            set_sizes(ra, na, rb, cb);
            repeat ($urandom_range(1, 3)) begin
                run_sequence();
                if ($urandom_range(0, 5) == 0) drain();
            end
            phase++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_MAX) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
